>>> sv/udg_pkg.sv
// Package for the unique digram stack: field types, status and opcode codes,
// the pad character and the character conversion functions.
// No dependencies; compiled before the interfaces and the top level.
package udg_pkg;

	localparam int DEFAULT_STACK_DEPTH = 64;

	typedef logic [1:0] opcode_t;
	typedef logic [7:0] char_t;
	typedef logic [6:0] occupancy_t;

	localparam opcode_t OP_CHAR = 2'd0;
	localparam opcode_t OP_END  = 2'd1;
	localparam opcode_t OP_POP  = 2'd2;

	typedef enum logic [2:0] {
		ST_PUSHED     = 3'd0,
		ST_DUP        = 3'd1,
		ST_WAIT       = 3'd2,
		ST_POPPED     = 3'd3,
		ST_EMPTY_POP  = 3'd4,
		ST_FULL       = 3'd5,
		ST_EMPTY_WORD = 3'd6
	} status_t;

	localparam char_t PAD_CHAR = 8'h20;

	// ASCII punctuation: the four printable ranges that are neither
	// letters, digits nor the space.
	function automatic logic is_punct(input char_t c);
		return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
		       (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
	endfunction

	// Punctuation becomes a space, lower case letters become upper case.
	function automatic char_t convert_char(input char_t c);
		if (is_punct(c)) begin
			return PAD_CHAR;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			return c - 8'h20;
		end else begin
			return c;
		end
	endfunction

endpackage

>>> sv/udg_if.sv
// Channel interfaces of the unique digram stack: the request channel that
// carries characters and commands, and the response channel with results.
// Depends on udg_pkg for the payload types.
interface udg_req_if;
	logic               valid;
	logic               ready;
	udg_pkg::opcode_t   opcode;
	udg_pkg::char_t     char_in;

	modport source (output valid, output opcode, output char_in, input ready);
	modport sink   (input valid, input opcode, input char_in, output ready);
endinterface

interface udg_rsp_if;
	logic                 valid;
	logic                 ready;
	udg_pkg::status_t     status;
	udg_pkg::char_t       first_char;
	udg_pkg::char_t       second_char;
	udg_pkg::occupancy_t  occupancy;

	modport source (output valid, output status, output first_char,
		output second_char, output occupancy, input ready);
	modport sink   (input valid, input status, input first_char,
		input second_char, input occupancy, output ready);
endinterface

>>> sv/unique_digram_stack.sv
// Top level of the unique digram stack: word assembly, duplicate scan over
// the digram memory, push and pop. Depends on udg_pkg and the interfaces
// in udg_if.sv.
//
// The block takes a word one character per request transaction, pairs the
// characters into upper-case digrams (punctuation turns into a space, an odd
// last character is padded with a space at end of word) and pushes each
// digram onto a stack unless the stack already holds it or is full. A pop request
// returns the top digram. Every request transaction gives exactly one
// response transaction carrying a status, the digram concerned and the
// occupancy after the step. A character that only starts a pair, an end of
// word with nothing pending, an empty pop and an ignored opcode have their
// response loaded on acceptance. A completed digram is compared against every
// stored entry, one entry per cycle through the single read port of the
// digram memory: the accept step, one read per entry, a compare of the last
// read, a step to leave the scan and the loading of the response, which waits
// while the output register cannot take it. A pop reads the top entry through
// the registered memory read port before it loads the response. The response
// sits in an output register; a new request is taken while the block is idle
// and that register is empty or is being drained in the same cycle. The
// memory needs no clearing after reset: only entries below the occupancy are
// read.
module unique_digram_stack #(
	parameter int STACK_DEPTH = udg_pkg::DEFAULT_STACK_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	udg_req_if.sink   req,
	udg_rsp_if.source rsp
);
	import udg_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_FIN  = 5'b00100,
		S_POP1 = 5'b01000,
		S_POP2 = 5'b10000
	} state_t;

	// Digram memory: first character in the high byte.
	logic [15:0] mem [STACK_DEPTH];

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ia_q;
	logic          rd_vld_s1;
	logic          match_q;
	logic [15:0]   rd_data_q;
	logic [15:0]   d_q;
	char_t         held_char_q;
	logic          held_valid_q;
	logic [1:0]    wls_q;

	logic          out_valid_q;
	status_t       status_q;
	char_t         first_q;
	char_t         second_q;
	occupancy_t    occ_q;

	logic          accept;
	logic          out_free;
	logic          issue;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          push_wr;

	// Response register may be loaded when empty or emptied this cycle.
	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;

	// The scan issues one read per cycle until every held entry is requested.
	assign issue   = (state_q == S_SCAN) && (ia_q < cnt_q);
	assign rd_en   = issue || (state_q == S_POP1);
	assign rd_addr = (state_q == S_POP1) ? cnt_q[AW-1:0] : ia_q[AW-1:0];
	assign push_wr = (state_q == S_FIN) && out_free && !match_q && (cnt_q != DEPTH_C);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (push_wr) begin
			mem[cnt_q[AW-1:0]] <= d_q;
		end
	end

	// Digram register, loaded on an accepted character or end of word.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (req.opcode == OP_CHAR && held_valid_q) begin
				d_q <= {convert_char(held_char_q), convert_char(req.char_in)};
			end else if (req.opcode == OP_END) begin
				d_q <= {convert_char(held_char_q), PAD_CHAR};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			ia_q         <= '0;
			rd_vld_s1    <= 1'b0;
			match_q      <= 1'b0;
			held_char_q  <= '0;
			held_valid_q <= 1'b0;
			wls_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.opcode)
							OP_CHAR: begin
								if (wls_q != 2'd2) begin
									wls_q <= wls_q + 2'd1;
								end
								if (!held_valid_q) begin
									held_char_q  <= req.char_in;
									held_valid_q <= 1'b1;
									out_valid_q  <= 1'b1;
								end else begin
									held_valid_q <= 1'b0;
									ia_q         <= '0;
									match_q      <= 1'b0;
									state_q      <= S_SCAN;
								end
							end
							OP_END: begin
								if (wls_q == 2'd0) begin
									out_valid_q <= 1'b1;
								end else if (!held_valid_q ||
								             (wls_q == 2'd1 && is_punct(held_char_q))) begin
									held_char_q  <= '0;
									held_valid_q <= 1'b0;
									wls_q        <= '0;
									out_valid_q  <= 1'b1;
								end else begin
									held_char_q  <= '0;
									held_valid_q <= 1'b0;
									wls_q        <= '0;
									ia_q         <= '0;
									match_q      <= 1'b0;
									state_q      <= S_SCAN;
								end
							end
							OP_POP: begin
								if (cnt_q == '0) begin
									out_valid_q <= 1'b1;
								end else begin
									cnt_q   <= cnt_q - 1'b1;
									state_q <= S_POP1;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue) begin
						ia_q <= ia_q + 1'b1;
					end
					if (rd_vld_s1 && rd_data_q == d_q) begin
						match_q <= 1'b1;
					end
					if (!issue && !rd_vld_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						if (push_wr) begin
							cnt_q <= cnt_q + 1'b1;
						end
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_POP1: begin
					state_q <= S_POP2;
				end
				S_POP2: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Response payload, loaded in every cycle that sets out_valid_q; an accept that starts a scan or a pop loads it too.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					first_q  <= '0;
					second_q <= '0;
					occ_q    <= occupancy_t'(cnt_q);
					if (req.opcode == OP_CHAR) begin
						status_q <= ST_WAIT;
					end else if (req.opcode == OP_END) begin
						if (wls_q == 2'd0 || (held_valid_q && wls_q == 2'd1 &&
						                      is_punct(held_char_q))) begin
							status_q <= ST_EMPTY_WORD;
						end else begin
							status_q <= ST_WAIT;
						end
					end else if (req.opcode == OP_POP) begin
						status_q <= ST_EMPTY_POP;
					end else begin
						status_q <= ST_WAIT;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					first_q  <= d_q[15:8];
					second_q <= d_q[7:0];
					if (match_q) begin
						status_q <= ST_DUP;
						occ_q    <= occupancy_t'(cnt_q);
					end else if (cnt_q == DEPTH_C) begin
						status_q <= ST_FULL;
						occ_q    <= occupancy_t'(cnt_q);
					end else begin
						status_q <= ST_PUSHED;
						occ_q    <= occupancy_t'(cnt_q + 1'b1);
					end
				end
			end
			S_POP2: begin
				if (out_free) begin
					status_q <= ST_POPPED;
					first_q  <= rd_data_q[15:8];
					second_q <= rd_data_q[7:0];
					occ_q    <= occupancy_t'(cnt_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.first_char  = first_q;
	assign rsp.second_char = second_q;
	assign rsp.occupancy   = occ_q;

endmodule

>>> dv/tb_unique_digram_stack.sv
`timescale 1ns / 100ps
// Self-checking testbench for unique_digram_stack: a directed table, a stack fill and
// drain, then random words, all scored against a digram stack predictor in this module.
// Depends on udg_pkg, the channel interfaces in udg_if.sv and the top level RTL.
module tb_unique_digram_stack;
	import udg_pkg::*;

	localparam int DEPTH = DEFAULT_STACK_DEPTH;
	localparam int N_RANDOM = 1700;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS = 40;

	// The package names three opcodes; the fourth code must be ignored by the block.
	localparam opcode_t OP_IGNORED = 2'd3;

	// One response transaction as the block should send it.
	typedef struct packed {
		status_t    status;
		char_t      first;
		char_t      second;
		occupancy_t occ;
	} digram_result_t;

	// One row of the directed table. Where fixed is set, res is the response typed in
	// by hand; otherwise the predictor supplies the expectation.
	typedef struct packed {
		opcode_t        op;
		char_t          ch;
		logic           fixed;
		digram_result_t res;
	} stim_row_t;

	localparam digram_result_t NO_RES = '{ST_WAIT, 8'h00, 8'h00, 7'd0};

	logic clk = 1'b0;
	logic arst_n;
	logic calm = 1'b0;

	udg_req_if req_ch ();
	udg_rsp_if rsp_ch ();

	unique_digram_stack #(
		.STACK_DEPTH(DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------------
	// Predictor state: the digram stack, its fill level and the word being assembled.
	// It is advanced once per accepted request transaction, in acceptance order.
	// ------------------------------------------------------------------------------
	logic [15:0]    stack_mem [DEPTH];
	int unsigned    stack_count = 0;
	char_t          pend_char = 8'h00;
	logic           pend_valid = 1'b0;
	logic [1:0]     word_len = 2'd0;
	digram_result_t result_q [$];

	int unsigned n_requests = 0;
	int unsigned n_responses = 0;
	int unsigned n_errors = 0;
	int unsigned deepest = 0;
	int unsigned status_seen [8];
	int unsigned stall_cycles = 0;

	// Printable characters that are neither a space, a letter nor a digit count as
	// punctuation.
	function automatic logic is_mark(input char_t c);
		logic letter;
		logic digit;
		letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
		digit = c >= "0" && c <= "9";
		return c > 8'h20 && c < 8'h7F && !letter && !digit;
	endfunction

	// Punctuation turns into a space and lower case letters lose bit 5; all other
	// codes, control and high codes too, go through as they are.
	function automatic char_t fold_char(input char_t c);
		if (is_mark(c)) begin
			return PAD_CHAR;
		end
		if (c >= "a" && c <= "z") begin
			return c & 8'hDF;
		end
		return c;
	endfunction

	// The duplicate scan covers every held entry and takes priority over the full check.
	function automatic status_t store_digram(input char_t a, input char_t b);
		for (int i = 0; i < stack_count; i++) begin
			if (stack_mem[i] == {a, b}) begin
				return ST_DUP;
			end
		end
		if (stack_count >= DEPTH) begin
			return ST_FULL;
		end
		stack_mem[stack_count] = {a, b};
		stack_count++;
		return ST_PUSHED;
	endfunction

	function automatic void clear_word();
		pend_char = 8'h00;
		pend_valid = 1'b0;
		word_len = 2'd0;
	endfunction

	function automatic digram_result_t predict_step(input opcode_t op, input char_t c);
		digram_result_t r;
		char_t a;
		r = NO_RES;
		case (op)
			OP_CHAR: begin
				if (word_len != 2'd2) begin
					word_len++;
				end
				if (!pend_valid) begin
					// The first character of a pair is kept raw until its partner comes.
					pend_char = c;
					pend_valid = 1'b1;
				end else begin
					a = fold_char(pend_char);
					pend_valid = 1'b0;
					r.first = a;
					r.second = fold_char(c);
					r.status = store_digram(a, r.second);
				end
			end
			OP_END: begin
				if (word_len == 2'd0) begin
					r.status = ST_EMPTY_WORD;
				end else if (!pend_valid) begin
					clear_word();
				end else if (word_len == 2'd1 && is_mark(pend_char)) begin
					// A word made of a single punctuation mark yields nothing.
					clear_word();
					r.status = ST_EMPTY_WORD;
				end else begin
					a = fold_char(pend_char);
					clear_word();
					r.first = a;
					r.second = PAD_CHAR;
					r.status = store_digram(a, PAD_CHAR);
				end
			end
			OP_POP: begin
				// A pop leaves any half-built word alone.
				if (stack_count == 0) begin
					r.status = ST_EMPTY_POP;
				end else begin
					stack_count--;
					{r.first, r.second} = stack_mem[stack_count];
					r.status = ST_POPPED;
				end
			end
			default: begin
			end
		endcase
		r.occ = occupancy_t'(stack_count);
		return r;
	endfunction

	// ------------------------------------------------------------------------------
	// Request side. Each call presents one transaction, with an occasional gap ahead of
	// it, and waits for the handshake. The expectation is queued at the very edge at
	// which the request is taken, so the predictor is always up to date on return.
	// ------------------------------------------------------------------------------
	task automatic send_request(input opcode_t op, input char_t ch,
			input logic fixed = 1'b0, input digram_result_t fixed_res = NO_RES);
		digram_result_t predicted;
		if (!calm && $urandom_range(99) < 8) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.char_in <= ch;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		predicted = predict_step(op, ch);
		result_q.push_back(fixed ? fixed_res : predicted);
		n_requests++;
	endtask

	// Random word characters: mostly letters of either case, sometimes from a four
	// letter alphabet so that duplicates are common, plus printable and arbitrary codes.
	function automatic char_t pick_word_char(input logic narrow);
		int unsigned r;
		char_t letter;
		r = $urandom_range(99);
		letter = char_t'(8'h61 + (narrow ? $urandom_range(3) : $urandom_range(25)));
		if (r < 60) begin
			return $urandom_range(1) ? letter : (letter & 8'hDF);
		end
		if (r < 80) begin
			return char_t'($urandom_range(8'h7E, 8'h20));
		end
		return char_t'($urandom_range(255));
	endfunction

	// The directed table. Rows whose response is obvious carry it typed in; the later
	// rows walk character codes at the edges of the punctuation and letter ranges, both
	// ends of the byte, and a pop in the middle of a word, and are left to the predictor.
	stim_row_t directed_rows [0:24] = '{
		'{OP_POP,     8'h00, 1'b1, '{ST_EMPTY_POP,  8'h00, 8'h00, 7'd0}},
		'{OP_END,     8'h00, 1'b1, '{ST_EMPTY_WORD, 8'h00, 8'h00, 7'd0}},
		'{OP_IGNORED, 8'hFF, 1'b1, '{ST_WAIT,       8'h00, 8'h00, 7'd0}},
		'{OP_CHAR,    "a",   1'b1, '{ST_WAIT,       8'h00, 8'h00, 7'd0}},
		'{OP_CHAR,    "b",   1'b1, '{ST_PUSHED,     "A",   "B",   7'd1}},
		'{OP_END,     8'h00, 1'b1, '{ST_WAIT,       8'h00, 8'h00, 7'd1}},
		'{OP_CHAR,    "A",   1'b1, '{ST_WAIT,       8'h00, 8'h00, 7'd1}},
		'{OP_CHAR,    "B",   1'b1, '{ST_DUP,        "A",   "B",   7'd1}},
		'{OP_END,     8'h00, 1'b1, '{ST_WAIT,       8'h00, 8'h00, 7'd1}},
		'{OP_CHAR,    "!",   1'b1, '{ST_WAIT,       8'h00, 8'h00, 7'd1}},
		'{OP_END,     8'h00, 1'b1, '{ST_EMPTY_WORD, 8'h00, 8'h00, 7'd1}},
		'{OP_CHAR,    "z",   1'b1, '{ST_WAIT,       8'h00, 8'h00, 7'd1}},
		'{OP_END,     8'h00, 1'b1, '{ST_PUSHED,     "Z",   " ",   7'd2}},
		'{OP_CHAR,    8'h00, 1'b0, NO_RES},
		'{OP_CHAR,    8'hFF, 1'b0, NO_RES},
		'{OP_CHAR,    8'h7E, 1'b0, NO_RES},
		'{OP_CHAR,    8'h60, 1'b0, NO_RES},
		'{OP_CHAR,    8'h7B, 1'b0, NO_RES},
		'{OP_CHAR,    8'h40, 1'b0, NO_RES},
		'{OP_CHAR,    "q",   1'b0, NO_RES},
		'{OP_POP,     8'h00, 1'b0, NO_RES},
		'{OP_CHAR,    8'h5B, 1'b0, NO_RES},
		'{OP_CHAR,    8'h2F, 1'b0, NO_RES},
		'{OP_END,     8'h00, 1'b0, NO_RES},
		'{OP_POP,     8'h00, 1'b0, NO_RES}
	};

	initial begin : stimulus
		int unsigned rand_base;
		int unsigned next_mix;
		int unsigned pop_pct;
		int unsigned sel;
		logic narrow;
		char_t a;
		char_t b;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_CHAR;
		req_ch.char_in <= 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].fixed,
				directed_rows[i].res);
		end

		// Fill the stack to the top with random pairs, then offer digrams that are most
		// likely not held (high codes are rare in the fill), a duplicate of the top
		// entry while full, and a padded odd word while full.
		while (stack_count < DEPTH) begin
			send_request(OP_CHAR, pick_word_char(1'b0));
			send_request(OP_CHAR, pick_word_char(1'b0));
		end
		send_request(OP_END, 8'h00);
		for (int k = 0; k < 3; k++) begin
			send_request(OP_CHAR, char_t'(8'h80 + k));
			send_request(OP_CHAR, 8'h90);
		end
		{a, b} = stack_mem[DEPTH - 1];
		send_request(OP_CHAR, a);
		send_request(OP_CHAR, b);
		send_request(OP_END, 8'h00);
		send_request(OP_CHAR, 8'hC0);
		send_request(OP_END, 8'h00);
		// Drain completely and pop once more on the empty stack.
		while (stack_count > 0) begin
			send_request(OP_POP, char_t'($urandom));
		end
		send_request(OP_POP, 8'hFF);

		// Random part: mostly well-formed words of zero to seven characters closed by an
		// end of word, with pops mixed in at a rate that changes every 150 transactions
		// so that the stack level swings between empty and full. A few words are left
		// open, and stray end-of-word and ignored-opcode transactions add noise. For a
		// stretch in the middle neither side idles.
		rand_base = n_requests;
		next_mix = n_requests;
		pop_pct = 20;
		narrow = 1'b0;
		while (n_requests - rand_base < N_RANDOM) begin
			if (n_requests >= next_mix) begin
				pop_pct = $urandom_range(40, 5);
				narrow = $urandom_range(2) == 0;
				next_mix += 150;
			end
			calm <= (n_requests - rand_base >= 600) && (n_requests - rand_base < 900);
			sel = $urandom_range(99);
			if (sel < pop_pct) begin
				send_request(OP_POP, char_t'($urandom));
			end else if (sel < pop_pct + 3) begin
				send_request(OP_IGNORED, char_t'($urandom));
			end else if (sel < pop_pct + 6) begin
				send_request(OP_END, char_t'($urandom));
			end else begin
				repeat ($urandom_range(7)) send_request(OP_CHAR, pick_word_char(narrow));
				if ($urandom_range(19) != 0) begin
					send_request(OP_END, char_t'($urandom));
				end
			end
		end
		req_ch.valid <= 1'b0;
		calm <= 1'b0;

		// Let every expected response arrive, then give the block time to show any
		// response that should not exist.
		while (result_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DEPTH + 8) @(posedge clk);

		$display("Ran %0d request and %0d response transactions; deepest stack %0d of %0d.",
			n_requests, n_responses, deepest, DEPTH);
		$display("Responses: %0d pushed, %0d duplicate, %0d popped, %0d empty pop,",
			status_seen[ST_PUSHED], status_seen[ST_DUP], status_seen[ST_POPPED],
			status_seen[ST_EMPTY_POP]);
		$display("  %0d full, %0d empty word, %0d waiting.",
			status_seen[ST_FULL], status_seen[ST_EMPTY_WORD], status_seen[ST_WAIT]);
		if (n_errors == 0) begin
			$display("PASS unique_digram_stack");
		end else begin
			$display("FAIL unique_digram_stack");
		end
		$finish;
	end

	// The response side stalls at random, with a chance of about 8 in a hundred, except in the calm stretch.
	always @(posedge clk) begin
		rsp_ch.ready <= calm || ($urandom_range(99) >= 8);
	end

	// ------------------------------------------------------------------------------
	// Response checking. Every accepted response transaction is matched against the
	// oldest queued expectation, field by field. Mismatch reports are capped so that a
	// broken block does not flood the log; the count keeps going.
	// ------------------------------------------------------------------------------
	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			n_errors++;
			if (n_errors <= MAX_REPORTS) begin
				$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field,
					want, got);
			end
		end
	endtask

	always @(posedge clk) begin : score_responses
		digram_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			n_responses++;
			if (rsp_ch.status <= ST_EMPTY_WORD) begin
				status_seen[rsp_ch.status]++;
			end
			if (rsp_ch.occupancy > deepest) begin
				deepest = rsp_ch.occupancy;
			end
			if (result_q.size() == 0) begin
				n_errors++;
				$display("%0t ns: response with nothing expected, status %0d digram 0x%02h%02h",
					$time, rsp_ch.status, rsp_ch.first_char, rsp_ch.second_char);
			end else begin
				want = result_q.pop_front();
				check_field("status", want.status, rsp_ch.status);
				check_field("first_char", want.first, rsp_ch.first_char);
				check_field("second_char", want.second, rsp_ch.second_char);
				check_field("occupancy", want.occ, rsp_ch.occupancy);
			end
		end
	end

	// Watchdog: counts cycles with work outstanding in which no transaction moves on
	// either channel. The longest legal wait is one full duplicate scan plus a stall.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				!(req_ch.valid || result_q.size() != 0)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("%0t ns: no transaction for %0d cycles, %0d responses outstanding",
				$time, WATCHDOG_LIMIT, result_q.size());
			$display("FAIL unique_digram_stack");
			$finish;
		end
	end

endmodule
